### rtl/core/sfq_pkg.sv
package sfq_pkg;

	localparam int DATA_W     = 32;
	localparam int SUM_W      = 36;
	localparam int MINLVL_W   = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam int SKEW       = 2;
	localparam int HEAD_RESET = 6;

	localparam logic [MINLVL_W-1:0] MIN_LEVEL_RESET      = 5'd4;
	localparam logic [DATA_W-1:0]   MIN_TOTAL_TIME_RESET = 32'd0;
	localparam logic [DATA_W-1:0]   UNDERRUN_VALUE       = 32'd1000;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_LEVEL      = 1'b0,
		REG_MIN_TOTAL_TIME = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic valid;
		logic rd;
		logic wr;
		logic ovf;
		logic und;
	} ctl_t;

endpackage

### rtl/core/sfq_ram.sv
module sfq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/skewed_step_fifo.sv
// Ring FIFO of step beats (delay + signal word) with fill level, running delay
// total and a needs-filling flag. After reset, busy stays high while the delay
// memory is cleared one slot a cycle; after that busy stays low and one command
// beat is taken every cycle. Each command gives exactly one result beat; it
// passes the s1 control register and then the done register, which drives done;
// results come in command order and cannot be held off, so the receiver must
// take every done beat. The delay of each write lands two slots behind its
// signal word, so a read returns the signals of one item with the delay of the
// item written two later. Writes to a full ring are dropped (overflow), reads of
// an empty ring return 1000/1000 (underrun). Throughput is set by the single
// registered-read port of each ring memory: one beat per cycle while busy is low.
module skewed_step_fifo #(
	parameter int DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                operation,
	input  logic [sfq_pkg::DATA_W-1:0]          time_before,
	input  logic [sfq_pkg::DATA_W-1:0]          signals,
	output logic                                done,
	output logic [sfq_pkg::DATA_W-1:0]          time_out,
	output logic [sfq_pkg::DATA_W-1:0]          signals_out,
	output logic [$clog2(DEPTH+1)-1:0]          fill_level,
	output logic [sfq_pkg::SUM_W-1:0]           total_time,
	output logic                                needs_filling,
	output logic                                overflow,
	output logic                                underrun,
	input  logic                                cfg_we,
	input  logic [sfq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sfq_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import sfq_pkg::*;

	localparam int AW    = $clog2(DEPTH);
	localparam int LVL_W = $clog2(DEPTH + 1);
	localparam int PW    = AW + 1;
	localparam int CMP_W = (LVL_W > MINLVL_W) ? LVL_W : MINLVL_W;
	localparam logic [AW-1:0] HEAD_RST = AW'(HEAD_RESET % DEPTH);

	logic [AW-1:0]         head_q;
	logic [LVL_W-1:0]      level_q;
	logic [SUM_W-1:0]      sum_q;
	logic [MINLVL_W-1:0]   min_level_q;
	logic [DATA_W-1:0]     min_time_q;
	logic                  clr_q;
	logic [AW-1:0]         clr_addr_q;

	ctl_t                  ctl_s1;
	logic [DATA_W-1:0]     time_s1;

	logic                  done_q;
	logic [DATA_W-1:0]     time_out_s2;
	logic [DATA_W-1:0]     signals_out_s2;
	logic [LVL_W-1:0]      level_s2;
	logic [SUM_W-1:0]      sum_s2;
	logic                  fill_s2;
	logic                  ovf_s2;
	logic                  und_s2;

	logic                  accept;
	logic                  is_read;
	logic                  full;
	logic                  empty;
	logic                  wr_take;
	logic                  rd_take;
	logic [PW-1:0]         pos;
	logic [PW-1:0]         sig_pos;
	logic [PW-1:0]         dly_pos;
	logic [AW-1:0]         sig_idx;
	logic [AW-1:0]         dly_idx;
	logic [AW-1:0]         head_nx;

	logic                  dly_we;
	logic [AW-1:0]         dly_waddr;
	logic [DATA_W-1:0]     dly_wdata;
	logic [DATA_W-1:0]     dly_rdata;
	logic [DATA_W-1:0]     sig_rdata;

	logic [SUM_W-1:0]      sum_nx;
	logic [DATA_W-1:0]     time_res;
	logic [DATA_W-1:0]     sig_res;
	logic                  fill_res;

	assign busy    = clr_q;
	assign accept  = start && !busy;
	assign is_read = (operation == OP_READ);
	assign full    = (level_q == LVL_W'(DEPTH));
	assign empty   = (level_q == '0);
	assign wr_take = accept && !is_read && !full;
	assign rd_take = accept && is_read && !empty;

	// slot positions: signal word at head+level, delay two slots behind
	assign pos     = PW'(head_q) + PW'(level_q);
	assign sig_pos = (pos >= PW'(DEPTH)) ? pos - PW'(DEPTH) : pos;
	assign dly_pos = (sig_pos >= PW'(SKEW)) ? sig_pos - PW'(SKEW)
	                                        : sig_pos + PW'(DEPTH - SKEW);
	assign sig_idx = sig_pos[AW-1:0];
	assign dly_idx = dly_pos[AW-1:0];
	assign head_nx = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;

	assign dly_we    = clr_q || wr_take;
	assign dly_waddr = clr_q ? clr_addr_q : dly_idx;
	assign dly_wdata = clr_q ? '0 : time_before;

	sfq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_delay_ram (
		.clk   (clk),
		.we    (dly_we),
		.waddr (dly_waddr),
		.wdata (dly_wdata),
		.raddr (head_q),
		.rdata (dly_rdata)
	);

	sfq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_signal_ram (
		.clk   (clk),
		.we    (wr_take),
		.waddr (sig_idx),
		.wdata (signals),
		.raddr (head_q),
		.rdata (sig_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= HEAD_RST;
			level_q    <= '0;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			ctl_s1     <= '0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (wr_take) begin
				level_q <= level_q + 1'b1;
			end else if (rd_take) begin
				level_q <= level_q - 1'b1;
				head_q  <= head_nx;
			end
			ctl_s1.valid <= accept;
			ctl_s1.wr    <= wr_take;
			ctl_s1.rd    <= rd_take;
			ctl_s1.ovf   <= accept && !is_read && full;
			ctl_s1.und   <= accept && is_read && empty;
		end
	end

	always_ff @(posedge clk) begin
		time_s1 <= time_before;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level_q <= MIN_LEVEL_RESET;
			min_time_q  <= MIN_TOTAL_TIME_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_MIN_LEVEL:      min_level_q <= cfg_data[MINLVL_W-1:0];
				REG_MIN_TOTAL_TIME: min_time_q  <= cfg_data[DATA_W-1:0];
			endcase
		end
	end

	// level_q already holds the post-op level during the s1 cycle
	always_comb begin
		sum_nx   = sum_q;
		time_res = '0;
		sig_res  = '0;
		if (ctl_s1.wr) begin
			sum_nx = sum_q + SUM_W'(time_s1);
		end else if (ctl_s1.rd) begin
			sum_nx   = sum_q - SUM_W'(dly_rdata);
			time_res = dly_rdata;
			sig_res  = sig_rdata;
		end else if (ctl_s1.und) begin
			time_res = UNDERRUN_VALUE;
			sig_res  = UNDERRUN_VALUE;
		end
		fill_res = (CMP_W'(level_q) < CMP_W'(min_level_q)) ||
		           (sum_nx < SUM_W'(min_time_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s1.valid;
			if (ctl_s1.valid) begin
				sum_q <= sum_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			time_out_s2    <= time_res;
			signals_out_s2 <= sig_res;
			level_s2       <= level_q;
			sum_s2         <= sum_nx;
			fill_s2        <= fill_res;
			ovf_s2         <= ctl_s1.ovf;
			und_s2         <= ctl_s1.und;
		end
	end

	assign done          = done_q;
	assign time_out      = time_out_s2;
	assign signals_out   = signals_out_s2;
	assign fill_level    = level_s2;
	assign total_time    = sum_s2;
	assign needs_filling = fill_s2;
	assign overflow      = ovf_s2;
	assign underrun      = und_s2;

`ifndef NO_ASSERTIONS
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LVL_W'(DEPTH))
		else $error("fill level beyond ring depth");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("command beat without result beat");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> (fill_level == LVL_W'(DEPTH)) && (time_out == '0))
		else $error("overflow reported on a ring that is not full");

	a_und_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && underrun) |-> (fill_level == '0) && (time_out == UNDERRUN_VALUE))
		else $error("underrun reported on a ring that is not empty");

	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> ($past(clr_addr_q) == AW'(DEPTH - 1)))
		else $error("clear pass ended early");
`endif

endmodule
